>>> hw/rtl/sbpg_pkg.sv
// ----------------------------------------------------------------------------
// sbpg_pkg - shared types for the swap/backtrack permutation generator
// Command codes, sequencer states and the element store control bundle.
// ----------------------------------------------------------------------------
package sbpg_pkg;

  localparam int unsigned SLOTS  = 8;   // positions on the result port
  localparam int unsigned IDX_W  = 3;   // index into the slots
  localparam int unsigned CNT_W  = 4;   // count of elements, 0..SLOTS
  localparam int unsigned ELEM_W = 16;  // element width

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,  // waiting for a transaction
    ST_UNDO = 2'd1,  // undo the swap of the current level
    ST_STEP = 2'd2,  // try the next choice of the level, or back up
    ST_EMIT = 2'd3   // hand the result to the output register
  } state_e;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ELEM_W-1:0] wr_data;
    logic              sw_en;
    logic [IDX_W-1:0]  sw_a;
    logic [IDX_W-1:0]  sw_b;
  } store_ctrl_t;

  typedef logic [SLOTS-1:0][ELEM_W-1:0] elem_vec_t;

endpackage

>>> hw/rtl/sbpg_swap_store.sv
// ----------------------------------------------------------------------------
// sbpg_swap_store - element store with one shared swap port
// Holds the loaded elements; per cycle does a clear, an append or one swap.
// ----------------------------------------------------------------------------
module sbpg_swap_store
  import sbpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  store_ctrl_t ctrl_i,
  output elem_vec_t   elems_o
);

  logic [SLOTS-1:0][ELEM_W-1:0] store_q;
  logic [ELEM_W-1:0]            rd_a;
  logic [ELEM_W-1:0]            rd_b;

  // swap unit read side
  assign rd_a = store_q[ctrl_i.sw_a];
  assign rd_b = store_q[ctrl_i.sw_b];

  // clear, append or exchange two slots; a swap of a slot with itself is a no-op
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (ctrl_i.clear) begin
      store_q <= '0;
    end else if (ctrl_i.wr_en) begin
      store_q[ctrl_i.wr_idx] <= ctrl_i.wr_data;
    end else if (ctrl_i.sw_en && (ctrl_i.sw_a != ctrl_i.sw_b)) begin
      store_q[ctrl_i.sw_a] <= rd_b;
      store_q[ctrl_i.sw_b] <= rd_a;
    end
  end

  assign elems_o = store_q;

endmodule

>>> hw/rtl/swap_backtrack_permutation_generator.sv
// ----------------------------------------------------------------------------
// swap_backtrack_permutation_generator - one result per next command
// Loads up to MAX_ELEMENTS values, then walks the swap-and-backtrack search
// with an explicit choice stack, one result per next transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | command_i, value_i
//  out     | output    | out_valid_o/out_ready_i | elem0_o..elem7_o, length_o,
//          |           |                         | is_final_o, none_left_o
//
//  Clear and append are taken in the idle state. A next for the first
//  permutation or a none_left answer goes from idle straight to the emit
//  step; otherwise it alternates an undo and a step state per level the
//  search backs up (at most 8), as the element store has a single swap port.
//  Reset is asynchronous and leaves an empty, unstarted search.
//  A stalled output holds the result; the block keeps taking transactions
//  and only waits in its emit step while the output register is full.
// ----------------------------------------------------------------------------
module swap_backtrack_permutation_generator
  import sbpg_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               command_i,
  input  logic signed [ELEM_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ELEM_W-1:0] elem0_o,
  output logic signed [ELEM_W-1:0] elem1_o,
  output logic signed [ELEM_W-1:0] elem2_o,
  output logic signed [ELEM_W-1:0] elem3_o,
  output logic signed [ELEM_W-1:0] elem4_o,
  output logic signed [ELEM_W-1:0] elem5_o,
  output logic signed [ELEM_W-1:0] elem6_o,
  output logic signed [ELEM_W-1:0] elem7_o,
  output logic [CNT_W-1:0]         length_o,
  output logic                     is_final_o,
  output logic                     none_left_o
);

  localparam logic [CNT_W-1:0] Cap = CNT_W'(MAX_ELEMENTS);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q;
  logic [SLOTS-1:0][IDX_W-1:0] stack_q;
  logic [CNT_W-1:0]         level_q;
  logic                     started_q, exhausted_q, overflow_q, have_q;
  logic                     out_valid_q;
  elem_vec_t                out_elem_q;
  logic [CNT_W-1:0]         out_len_q;
  logic                     out_final_q, out_none_q;

  store_ctrl_t              ctrl;
  elem_vec_t                elems;
  logic                     accept, out_free, last_leaf;
  cmd_e                     cmd;
  logic [CNT_W-1:0]         lvl_w, next_choice, count_m1;
  logic [IDX_W-1:0]         lvl;
  logic                     choice_ok, next_quick;

  sbpg_swap_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .elems_o (elems)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);
  assign out_free   = !out_valid_q || out_ready_i;

  // current level and its next choice
  assign lvl_w       = level_q - CNT_W'(1);
  assign lvl         = lvl_w[IDX_W-1:0];
  assign next_choice = {1'b0, stack_q[lvl]} + CNT_W'(1);
  assign choice_ok   = (next_choice < count_q);
  assign count_m1    = count_q - CNT_W'(1);

  // a next that needs no search walk
  assign next_quick = overflow_q || exhausted_q || !started_q || (count_q == '0);

  // last leaf: every level holds the last choice
  always_comb begin
    last_leaf = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if ((CNT_W'(k) < count_q) && ({1'b0, stack_q[k]} != count_m1)) begin
        last_leaf = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd == CMD_NEXT)) begin
          state_d = next_quick ? ST_EMIT : ST_UNDO;
        end
      end
      ST_UNDO: state_d = ST_STEP;
      ST_STEP: begin
        if (choice_ok || (lvl == '0)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_UNDO;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store control
  always_comb begin
    ctrl         = '0;
    ctrl.wr_idx  = count_q[IDX_W-1:0];
    ctrl.wr_data = value_i;
    ctrl.sw_a    = lvl;
    ctrl.sw_b    = stack_q[lvl];
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd == CMD_CLEAR)) begin
          ctrl.clear = 1'b1;
        end
        if (accept && (cmd == CMD_APPEND) && !started_q && (count_q < Cap)) begin
          ctrl.wr_en = 1'b1;
        end
      end
      ST_UNDO: ctrl.sw_en = 1'b1;
      ST_STEP: begin
        ctrl.sw_b  = next_choice[IDX_W-1:0];
        ctrl.sw_en = choice_ok;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stack_q     <= '0;
      level_q     <= '0;
      started_q   <= 1'b0;
      exhausted_q <= 1'b0;
      overflow_q  <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR: begin
                count_q     <= '0;
                stack_q     <= '0;
                level_q     <= '0;
                started_q   <= 1'b0;
                exhausted_q <= 1'b0;
                overflow_q  <= 1'b0;
              end
              CMD_APPEND: begin
                if (!started_q) begin
                  if (count_q >= Cap) begin
                    overflow_q <= 1'b1;
                  end else begin
                    count_q <= count_q + CNT_W'(1);
                  end
                end
              end
              CMD_NEXT: begin
                if (overflow_q || exhausted_q) begin
                  have_q <= 1'b0;
                end else if (!started_q) begin
                  // first permutation is the loaded order
                  started_q <= 1'b1;
                  for (int k = 0; k < SLOTS; k++) begin
                    stack_q[k] <= IDX_W'(k);
                  end
                  level_q <= count_q;
                  have_q  <= 1'b1;
                end else if (count_q == '0) begin
                  exhausted_q <= 1'b1;
                  have_q      <= 1'b0;
                end else begin
                  level_q <= count_q;
                end
              end
              default: have_q <= have_q;
            endcase
          end
        end
        ST_UNDO: have_q <= have_q;
        ST_STEP: begin
          if (choice_ok) begin
            // take the next choice here, restart the deeper levels
            stack_q[lvl] <= next_choice[IDX_W-1:0];
            for (int k = 0; k < SLOTS; k++) begin
              if (IDX_W'(k) > lvl) begin
                stack_q[k] <= IDX_W'(k);
              end
            end
            level_q <= count_q;
            have_q  <= 1'b1;
          end else if (lvl == '0) begin
            exhausted_q <= 1'b1;
            level_q     <= '0;
            have_q      <= 1'b0;
          end else begin
            level_q <= lvl_w;
          end
        end
        ST_EMIT: have_q <= have_q;
        default: have_q <= have_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      for (int k = 0; k < SLOTS; k++) begin
        out_elem_q[k] <= (have_q && (CNT_W'(k) < count_q)) ? elems[k] : '0;
      end
      out_len_q   <= have_q ? count_q : '0;
      out_final_q <= have_q && last_leaf;
      out_none_q  <= !have_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign elem0_o     = out_elem_q[0];
  assign elem1_o     = out_elem_q[1];
  assign elem2_o     = out_elem_q[2];
  assign elem3_o     = out_elem_q[3];
  assign elem4_o     = out_elem_q[4];
  assign elem5_o     = out_elem_q[5];
  assign elem6_o     = out_elem_q[6];
  assign elem7_o     = out_elem_q[7];
  assign length_o    = out_len_q;
  assign is_final_o  = out_final_q;
  assign none_left_o = out_none_q;

  // the walk only runs inside a started search
  a_walk_started : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UNDO) || (state_q == ST_STEP)) |-> started_q)
    else $error("search walk without a started search");

  // a none_left answer carries no permutation
  a_none_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_left_o) |-> ((length_o == '0) && !is_final_o))
    else $error("none_left result with permutation data");

  // a result never exceeds the capacity
  a_len_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= Cap))
    else $error("result length above capacity");

  // the count never passes the capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == CMD_APPEND)) |=> (count_q <= Cap))
    else $error("element count above capacity");

endmodule

>>> tb/tb_swap_backtrack_permutation_generator.sv
// ----------------------------------------------------------------------------
// tb_swap_backtrack_permutation_generator - self-checking bench
// Loads element sets, walks the permutation order with next transactions and
// checks every result against a behavioral copy of the backtracking search.
// Both handshakes idle and stall at random; clears, overflowing loads,
// appends during a search and unknown commands are mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_swap_backtrack_permutation_generator;
  import sbpg_pkg::*;

  localparam int unsigned PERM_CAP   = 8;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;  // not decoded by the block
  localparam int          ITEM_GOAL  = 1150;
  localparam int          TAIL_WAIT  = 60;    // beyond the worst next latency
  localparam int          REPORT_MAX = 10;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] value;
    int          gap;
    bit          drain;  // hold off until all results are back
  } pending_t;

  typedef struct packed {
    logic [SLOTS-1:0][ELEM_W-1:0] elem;
    logic [CNT_W-1:0]             length;
    logic                         is_final;
    logic                         none_left;
  } perm_result_t;

  // Clock, reset and DUT ports
  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cmd = CMD_CLEAR;
  logic [15:0]       in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       got_elem [SLOTS];
  logic [CNT_W-1:0]  got_length;
  logic              got_final;
  logic              got_none;

  pending_t          item_q [$];
  perm_result_t      perm_q [$];
  pending_t          nxt_item;
  int                wait_cnt;
  int                stall_left;
  bit                rx_calm;
  bit                tx_calm;
  int                errors;

  // Behavioral copy of the search state
  logic [15:0]       perm_elems [SLOTS];
  int unsigned       perm_len;
  int unsigned       perm_pick [SLOTS];
  bit                perm_started;
  bit                perm_done;
  bit                perm_overflow;

  swap_backtrack_permutation_generator #(
    .MAX_ELEMENTS(PERM_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .command_i  (in_cmd),
    .value_i    (in_value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .elem0_o    (got_elem[0]),
    .elem1_o    (got_elem[1]),
    .elem2_o    (got_elem[2]),
    .elem3_o    (got_elem[3]),
    .elem4_o    (got_elem[4]),
    .elem5_o    (got_elem[5]),
    .elem6_o    (got_elem[6]),
    .elem7_o    (got_elem[7]),
    .length_o   (got_length),
    .is_final_o (got_final),
    .none_left_o(got_none)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Search model
  // --------------------------------------------------------------------------
  function automatic void perm_clear();
    for (int k = 0; k < SLOTS; k++) begin
      perm_elems[k] = '0;
      perm_pick[k]  = 0;
    end
    perm_len      = 0;
    perm_started  = 1'b0;
    perm_done     = 1'b0;
    perm_overflow = 1'b0;
  endfunction

  function automatic void perm_swap(int unsigned a, int unsigned b);
    logic [15:0] t;
    t             = perm_elems[a];
    perm_elems[a] = perm_elems[b];
    perm_elems[b] = t;
  endfunction

  // Undo levels from the bottom until one has a further choice; 0 when done
  function automatic bit perm_advance();
    int unsigned lvl;
    int unsigned j;
    for (int d = perm_len; d > 0; d--) begin
      lvl = d - 1;
      j   = perm_pick[lvl];
      perm_swap(lvl, j);
      j++;
      if (j < perm_len) begin
        perm_pick[lvl] = j;
        perm_swap(lvl, j);
        for (int unsigned k = lvl + 1; k < perm_len; k++) perm_pick[k] = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit perm_is_last();
    for (int unsigned k = 0; k < perm_len; k++)
      if (perm_pick[k] != perm_len - 1) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted transaction; a next queues its expected result
  function automatic void perm_apply(logic [1:0] cmd, logic [15:0] value);
    perm_result_t r;
    bit           have;
    r = '0;
    case (cmd)
      CMD_CLEAR: perm_clear();
      CMD_APPEND: begin
        if (!perm_started) begin
          if (perm_len >= PERM_CAP) begin
            perm_overflow = 1'b1;
          end else begin
            perm_elems[perm_len] = value;
            perm_len++;
          end
        end
      end
      CMD_NEXT: begin
        if (perm_overflow || perm_done) begin
          have = 1'b0;
        end else if (!perm_started) begin
          perm_started = 1'b1;
          for (int k = 0; k < SLOTS; k++) perm_pick[k] = k;
          have = 1'b1;
        end else begin
          have = perm_advance();
          if (!have) perm_done = 1'b1;
        end
        if (have) begin
          for (int unsigned k = 0; k < perm_len; k++) r.elem[k] = perm_elems[k];
          r.length   = CNT_W'(perm_len);
          r.is_final = perm_is_last();
        end else begin
          r.none_left = 1'b1;
        end
        perm_q = {perm_q, r};
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(string what, int expv, int actv);
    errors++;
    if (errors <= REPORT_MAX)
      $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
  endfunction

  function automatic void check_result();
    perm_result_t e;
    if (perm_q.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX) $display("mismatch: result with none outstanding");
      return;
    end
    e = perm_q.pop_front();
    for (int k = 0; k < SLOTS; k++)
      if (got_elem[k] !== e.elem[k])
        note_mismatch($sformatf("elem%0d", k), $signed(e.elem[k]), $signed(got_elem[k]));
    if (got_length !== e.length)   note_mismatch("length", e.length, got_length);
    if (got_final !== e.is_final)  note_mismatch("is_final", e.is_final, got_final);
    if (got_none !== e.none_left)  note_mismatch("none_left", e.none_left, got_none);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued transactions after their gap
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cmd   <= CMD_CLEAR;
      in_value <= '0;
      wait_cnt = 0;
    end else begin
      if (in_valid && in_ready) perm_apply(in_cmd, in_value);
      if (in_valid && !in_ready) begin
        // hold the payload until accepted
      end else if (item_q.size() != 0 && !(item_q[0].drain && perm_q.size() != 0) &&
                   wait_cnt >= item_q[0].gap) begin
        nxt_item = item_q.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt_item.cmd;
        in_value <= nxt_item.value;
        wait_cnt = 0;
      end else begin
        in_valid <= 1'b0;
        if (item_q.size() != 0 && wait_cnt < item_q[0].gap) wait_cnt++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results and stalls the output at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      rx_calm    = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        stall_left = rx_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_item(logic [1:0] cmd, logic [15:0] value, bit drain = 1'b0);
    pending_t p;
    p.cmd   = cmd;
    p.value = value;
    p.gap   = tx_calm ? 0 : $urandom_range(0, 8);
    p.drain = drain;
    item_q = {item_q, p};
  endfunction

  function automatic int perm_total(int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) f *= k;
    return f;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int issued;
    int rounds;
    int n;
    int nexts;
    int roll;

    errors  = 0;
    tx_calm = 1'b0;
    perm_clear();

    // Directed: empty load, appends once the search has started, ignored commands
    add_item(CMD_CLEAR, 16'h0000);
    add_item(CMD_NEXT, 16'h0000);
    add_item(CMD_NEXT, 16'hFFFF);
    add_item(CMD_APPEND, 16'h8000);
    add_item(CMD_APPEND, 16'h7FFF);
    add_item(CMD_APPEND, 16'hFFFF);
    repeat (7) add_item(CMD_NEXT, 16'h0000);
    add_item(CMD_APPEND, 16'h1234);  // search started: ignored
    add_item(CMD_UNUSED, 16'hAAAA);
    add_item(CMD_NEXT, 16'h0000);
    // overflowing load
    add_item(CMD_CLEAR, 16'h5555, 1'b1);
    for (int k = 0; k < PERM_CAP + 1; k++) add_item(CMD_APPEND, 16'(16'h0101 * (k + 1)));
    add_item(CMD_NEXT, 16'h0000);
    issued = 27;

    // Random rounds: load a set, then walk part or all of its order
    rounds = 0;
    while (issued < ITEM_GOAL) begin
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      roll = $urandom_range(0, 99);
      if (roll < 5)       n = PERM_CAP + 1 + $urandom_range(0, 1);
      else if (roll < 15) n = $urandom_range(5, PERM_CAP);
      else                n = $urandom_range(0, 4);

      if ($urandom_range(0, 19) != 0) begin
        add_item(CMD_CLEAR, 16'($urandom), (rounds % 8) == 7);
        issued++;
      end
      for (int k = 0; k < n; k++) add_item(CMD_APPEND, pick_value());
      issued += n;

      if (n > PERM_CAP)       nexts = $urandom_range(1, 3);
      else if (n > 4)         nexts = $urandom_range(1, 24);
      else if ($urandom_range(0, 4) != 0) nexts = perm_total(n) + $urandom_range(0, 2);
      else                    nexts = $urandom_range(1, perm_total(n));

      for (int k = 0; k < nexts; k++) begin
        if ($urandom_range(0, 19) == 0)
          add_item($urandom_range(0, 1) ? CMD_UNUSED : CMD_APPEND, 16'($urandom));
        add_item(CMD_NEXT, 16'($urandom));
      end
      issued += nexts;
      rounds++;
    end

    // Reset, then wait for the queue to drain
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    while (item_q.size() != 0 || in_valid) @(posedge clk_i);
    while (perm_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> swap_backtrack_permutation_generator.f
hw/rtl/sbpg_pkg.sv
hw/rtl/sbpg_swap_store.sv
hw/rtl/swap_backtrack_permutation_generator.sv
tb/tb_swap_backtrack_permutation_generator.sv
